// ----- src/assert_macros.svh -----
// Assertion macros shared by the formatter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(name, pre, post)
`define ASSERT_NEXT(name, pre, post)
`endif
`endif

// ----- src/itf_pkg.sv -----
// Types and constants of the integer to text formatter
package itf_pkg;

	localparam int VALUE_BITS = 64;
	localparam int VAL_W      = 64;
	localparam int DEC_BITS   = 32;
	localparam int STEP_BITS  = 4;
	localparam int DAB_STAGES = DEC_BITS / STEP_BITS;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
	localparam int DIGITS     = (HEX_DIGITS > BCD_DIGITS) ? HEX_DIGITS : BCD_DIGITS;
	localparam int HEX_CHARS  = 2 + HEX_DIGITS;
	localparam int CHARS      = (HEX_CHARS > BCD_DIGITS + 1) ? HEX_CHARS : BCD_DIGITS + 1;
	localparam int IDX_W      = $clog2(DIGITS);
	localparam int POS_W      = $clog2(CHARS + 1);

	localparam logic [VAL_W-1:0] VALUE_MASK = {VAL_W{1'b1}} >> (VAL_W - VALUE_BITS);

	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] ALPHA_OFS = 8'd87;
	localparam logic [7:0] CASE_OFS  = 8'd32;

	typedef enum logic [2:0] {
		MODE_SDEC = 3'd0,
		MODE_UDEC = 3'd1,
		MODE_HEXL = 3'd2,
		MODE_HEXU = 3'd3,
		MODE_PTR  = 3'd4
	} mode_t;

	// decimal items carry the magnitude in value[DEC_BITS-1:0], consumed by the cells
	typedef struct packed {
		mode_t             mode;
		logic              neg;
		logic [VAL_W-1:0]  value;
		logic [BCD_W-1:0]  bcd;
	} item_t;

endpackage

// ----- src/integer_to_text_formatter.sv -----
// Integer to text formatter top level
// Takes one mode and value per transfer and sends the ASCII text one character per
// transfer, most significant first, with last on the final character. Output runs at one
// character per cycle while char_stall is low, with no gap between items that are ready;
// an item has 1 to 18 characters (up to 11 for decimal, up to 18 for a pointer). Items
// pass through the chain of converter cells, each shifting four bits of the 32-bit
// decimal magnitude into a ten-digit BCD register; hex items ride the same chain so
// order is kept. Items with mode codes 5 to 7 are taken and produce no output.
`include "assert_macros.svh"
module integer_to_text_formatter import itf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic [2:0]       mode,
	input  logic [VAL_W-1:0] value,
	output logic             char_valid,
	input  logic             char_stall,
	output logic [7:0]       text_char,
	output logic             last
);

	item_t entry;
	logic  entry_ok;
	item_t stage_d [DAB_STAGES+1];
	logic  stage_v [DAB_STAGES+1];
	logic  stage_s [DAB_STAGES+1];

	always_comb begin : admit
		logic [DEC_BITS-1:0] low;
		logic [DEC_BITS-1:0] mag;
		low        = value[DEC_BITS-1:0];
		mag        = ~low + DEC_BITS'(1);
		entry.mode = mode_t'(mode);
		entry.neg  = 1'b0;
		entry.value = value & VALUE_MASK;
		entry.bcd  = '0;
		case (mode_t'(mode)) inside
			MODE_SDEC: begin
				entry_ok = 1'b1;
				if (low[DEC_BITS-1]) begin
					entry.neg   = 1'b1;
					entry.value = VAL_W'(mag);
				end else begin
					entry.value = VAL_W'(low);
				end
			end
			MODE_UDEC: begin
				entry_ok    = 1'b1;
				entry.value = VAL_W'(low);
			end
			MODE_HEXL, MODE_HEXU, MODE_PTR: begin
				entry_ok = 1'b1;
			end
			default: begin
				entry_ok = 1'b0;
			end
		endcase
	end

	assign stage_v[0] = item_valid && entry_ok;
	assign stage_d[0] = entry;
	assign item_stall = stage_s[0];

	for (genvar g = 0; g < DAB_STAGES; g++) begin : g_cell
		itf_dabble_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (stage_v[g]),
			.up_item  (stage_d[g]),
			.up_stall (stage_s[g]),
			.dn_valid (stage_v[g+1]),
			.dn_item  (stage_d[g+1]),
			.dn_stall (stage_s[g+1])
		);
	end

	itf_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (stage_v[DAB_STAGES]),
		.up_item    (stage_d[DAB_STAGES]),
		.up_stall   (stage_s[DAB_STAGES]),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.text_char  (text_char),
		.last       (last)
	);

	`ASSERT_IMP(a_dec_narrow, stage_v[0] && (entry.mode == MODE_SDEC || entry.mode == MODE_UDEC), entry.value[VAL_W-1:DEC_BITS] == '0)
	`ASSERT_NEXT(a_out_drains, stage_v[DAB_STAGES] && !stage_s[DAB_STAGES], char_valid)

endmodule

// ----- src/itf_dabble_cell.sv -----
// One pipeline cell of the binary to BCD converter, STEP_BITS bits per cell
`include "assert_macros.svh"
module itf_dabble_cell import itf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	input  item_t up_item,
	output logic  up_stall,
	output logic  dn_valid,
	output item_t dn_item,
	input  logic  dn_stall
);

	item_t next_item;
	item_t data_q;
	logic  valid_q;

	always_comb begin : dabble
		logic [BCD_W+DEC_BITS-1:0] acc;
		next_item = up_item;
		acc = {up_item.bcd, up_item.value[DEC_BITS-1:0]};
		for (int s = 0; s < STEP_BITS; s++) begin
			for (int d = 0; d < BCD_DIGITS; d++) begin
				if (acc[DEC_BITS+4*d +: 4] >= 4'd5) begin
					acc[DEC_BITS+4*d +: 4] = acc[DEC_BITS+4*d +: 4] + 4'd3;
				end
			end
			acc = acc << 1;
		end
		case (up_item.mode) inside
			MODE_SDEC, MODE_UDEC: begin
				next_item.bcd   = acc[BCD_W+DEC_BITS-1:DEC_BITS];
				next_item.value = VAL_W'(acc[DEC_BITS-1:0]);
			end
			default: begin
				next_item = up_item;
			end
		endcase
	end

	assign up_stall = valid_q && dn_stall;
	assign dn_valid = valid_q;
	assign dn_item  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!up_stall) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			data_q <= next_item;
		end
	end

	`ASSERT_NEXT(a_stage_hold, valid_q && dn_stall, valid_q && $stable(data_q.value))

endmodule

// ----- src/itf_serializer.sv -----
// Character shift row: builds the text of one item and sends it one transfer per cycle while char_stall is low
`include "assert_macros.svh"
module itf_serializer import itf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       up_valid,
	input  item_t      up_item,
	output logic       up_stall,
	output logic       char_valid,
	input  logic       char_stall,
	output logic [7:0] text_char,
	output logic       last
);

	logic [7:0] char_q [CHARS];
	logic       last_q [CHARS];
	logic       valid_q;
	logic [7:0] load_char [CHARS];
	logic       load_last [CHARS];
	logic       xfer;
	logic       load_ok;

	assign xfer     = valid_q && !char_stall;
	// refill on the cycle the final character leaves, so bursts run back to back
	assign load_ok  = !valid_q || (xfer && last_q[0]);
	assign up_stall = !load_ok;

	always_comb begin : build
		logic [4*DIGITS-1:0] dec_ext;
		logic [4*DIGITS-1:0] hex_ext;
		logic [3:0]          dig [DIGITS];
		logic [7:0]          dch [DIGITS];
		logic                is_dec;
		logic                upper;
		logic [POS_W-1:0]    plen;
		logic [POS_W-1:0]    ndig;
		logic [POS_W-1:0]    fin;
		logic [POS_W-1:0]    pos;
		logic [POS_W-1:0]    k;
		logic [IDX_W-1:0]    sel;
		dec_ext = (4*DIGITS)'(up_item.bcd);
		hex_ext = (4*DIGITS)'(up_item.value);
		upper   = (up_item.mode == MODE_HEXU);
		case (up_item.mode) inside
			MODE_SDEC, MODE_UDEC: is_dec = 1'b1;
			default:              is_dec = 1'b0;
		endcase
		case (up_item.mode)
			MODE_SDEC: plen = up_item.neg ? POS_W'(1) : POS_W'(0);
			MODE_PTR:  plen = POS_W'(2);
			default:   plen = POS_W'(0);
		endcase
		for (int i = 0; i < DIGITS; i++) begin
			dig[i] = is_dec ? dec_ext[4*i +: 4] : hex_ext[4*i +: 4];
			if (dig[i] < 4'd10) begin
				dch[i] = CH_ZERO + {4'b0, dig[i]};
			end else begin
				dch[i] = {4'b0, dig[i]} + ALPHA_OFS - (upper ? CASE_OFS : 8'd0);
			end
		end
		// zero still prints one digit
		ndig = POS_W'(1);
		for (int i = 1; i < DIGITS; i++) begin
			if (dig[i] != 4'd0) begin
				ndig = POS_W'(i + 1);
			end
		end
		fin = plen + ndig - POS_W'(1);
		for (int p = 0; p < CHARS; p++) begin
			pos = POS_W'(p);
			k   = pos - plen;
			sel = IDX_W'(ndig - POS_W'(1) - k);
			if (pos < plen) begin
				if (up_item.mode == MODE_PTR) begin
					load_char[p] = (pos == POS_W'(0)) ? CH_ZERO : CH_X;
				end else begin
					load_char[p] = CH_MINUS;
				end
			end else if (k < ndig) begin
				load_char[p] = dch[sel];
			end else begin
				load_char[p] = 8'd0;
			end
			load_last[p] = (pos == fin);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ok) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && up_valid) begin
			for (int p = 0; p < CHARS; p++) begin
				char_q[p] <= load_char[p];
				last_q[p] <= load_last[p];
			end
		end else if (xfer) begin
			for (int p = 0; p < CHARS - 1; p++) begin
				char_q[p] <= char_q[p+1];
				last_q[p] <= last_q[p+1];
			end
			char_q[CHARS-1] <= 8'd0;
			last_q[CHARS-1] <= 1'b0;
		end
	end

	assign char_valid = valid_q;
	assign text_char  = char_q[0];
	assign last       = last_q[0];

	`ASSERT_NEXT(a_burst_continues, valid_q && !char_stall && !last_q[0], valid_q)
	`ASSERT_NEXT(a_load_shows, up_valid && load_ok, valid_q)

endmodule

// ----- verif/integer_to_text_checker.sv -----
// Checker for the integer to text formatter: predicts the text of each item and compares it
`timescale 1ns / 100ps

module integer_to_text_checker import itf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_stall,
	input  logic [2:0]       mode,
	input  logic [VAL_W-1:0] value,
	input  logic             char_valid,
	input  logic             char_stall,
	input  logic [7:0]       text_char,
	input  logic             last,
	output int               mismatches,
	output int               pending,
	output int               chars_seen
);

	localparam logic [63:0] HEX_VIEW = {64{1'b1}} >> (64 - VALUE_BITS);

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} text_beat_t;

	text_beat_t expected_text[$];
	text_beat_t want;

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// queue the characters that one item should produce
	task automatic queue_text(input logic [2:0] m, input logic [VAL_W-1:0] v);
		logic [7:0]  txt[$];
		logic [7:0]  digs[$];
		logic [63:0] mag;
		logic [63:0] radix;
		logic [63:0] d;
		logic [7:0]  ch;
		logic [31:0] low;
		bit          upper;
		text_beat_t  beat;
		upper = 1'b0;
		low   = v[31:0];
		radix = 64'd16;
		mag   = v & HEX_VIEW;
		case (m)
			MODE_SDEC: begin
				radix = 64'd10;
				mag   = {32'd0, low};
				if (low[31]) begin
					txt.push_back(CH_MINUS);
					// magnitude as unsigned 32 bits, so the most negative value works
					mag = {32'd0, 32'd0 - low};
				end
			end
			MODE_UDEC: begin
				radix = 64'd10;
				mag   = {32'd0, low};
			end
			MODE_HEXL: ;
			MODE_HEXU: upper = 1'b1;
			MODE_PTR: begin
				txt.push_back(CH_ZERO);
				txt.push_back(CH_X);
			end
			default: return;
		endcase
		do begin
			d = mag % radix;
			if (d < 10)
				ch = CH_ZERO + d[7:0];
			else begin
				ch = d[7:0] + ALPHA_OFS;
				if (upper)
					ch = ch - CASE_OFS;
			end
			digs.push_front(ch);
			mag = mag / radix;
		end while (mag != 0);
		foreach (digs[k])
			txt.push_back(digs[k]);
		foreach (txt[k]) begin
			beat.ch  = txt[k];
			beat.fin = (k == txt.size() - 1);
			expected_text.push_back(beat);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_text.delete();
			mismatches = 0;
			chars_seen = 0;
			pending   <= 0;
		end else begin
			if (item_valid && !item_stall)
				queue_text(mode, value);
			if (char_valid && !char_stall) begin
				chars_seen++;
				if (expected_text.size() == 0)
					report_mismatch($sformatf("character %h with no text expected", text_char));
				else begin
					want = expected_text.pop_front();
					if (text_char !== want.ch)
						report_mismatch($sformatf("text_char %h, expected %h", text_char, want.ch));
					if (last !== want.fin)
						report_mismatch($sformatf("last %b, expected %b", last, want.fin));
				end
			end
			pending <= expected_text.size();
		end
	end

endmodule

// ----- verif/integer_to_text_formatter_tb.sv -----
// Testbench top for the integer to text formatter: stimulus, stalls, watchdog and verdict
`timescale 1ns / 100ps

module integer_to_text_formatter_tb import itf_pkg::*; ();

	localparam int          DIRECTED_ITEMS = 21;
	localparam int          RANDOM_ITEMS  = 110;
	localparam int          IDLE_LIMIT    = 3000;
	localparam int          SETTLE_CYCLES = 40;
	localparam logic [2:0]  FIRST_UNUSED  = 3'd5;
	localparam logic [2:0]  LAST_UNUSED   = 3'd7;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	logic [2:0]       mode       = '0;
	logic [VAL_W-1:0] value      = '0;
	logic             char_valid;
	logic             char_stall = 1'b0;
	logic [7:0]       text_char;
	logic             last;

	int mismatches;
	int pending;
	int chars_seen;
	int items_sent    = 0;
	int unused_sent   = 0;
	int idle_cycles   = 0;
	int stall_hold    = 0;
	bit quiet         = 1'b0;

	always #2 clk = ~clk;

	integer_to_text_formatter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.mode       (mode),
		.value      (value),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.text_char  (text_char),
		.last       (last)
	);

	integer_to_text_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.mode       (mode),
		.value      (value),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.text_char  (text_char),
		.last       (last),
		.mismatches (mismatches),
		.pending    (pending),
		.chars_seen (chars_seen)
	);

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold--;
			char_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 99) < 25) begin
			stall_hold = pick_gap() - 1;
			char_stall <= 1'b1;
		end else
			char_stall <= 1'b0;
	end

	// any cycle without a transfer on either channel counts toward the limit
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (char_valid && !char_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [2:0] m, input logic [VAL_W-1:0] v);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 99) < 40)
			gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		mode       <= m;
		value      <= v;
		do @(posedge clk); while (item_stall);
		if (m > MODE_PTR)
			unused_sent++;
		else
			items_sent++;
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [VAL_W-1:0] random_value();
		logic [VAL_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 4))
			0: return VAL_W'($urandom_range(0, 20));
			1: return v;
			2: return v >> $urandom_range(0, 63);
			3: return {v[63:32], 1'b1, v[30:0]};
			default: return v >> $urandom_range(32, 60);
		endcase
	endfunction

	initial begin
		int m;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// signed decimal: zero, one, minus one, both 32-bit extremes, high bits ignored
		send_item(MODE_SDEC, 64'd0);
		send_item(MODE_SDEC, 64'd1);
		send_item(MODE_SDEC, 64'h0000_0000_ffff_ffff);
		send_item(MODE_SDEC, 64'h0000_0000_8000_0000);
		send_item(MODE_SDEC, 64'h0000_0000_7fff_ffff);
		send_item(MODE_SDEC, 64'hffff_ffff_ffff_ff85);
		send_item(MODE_SDEC, 64'hffff_ffff_0000_0000);
		send_item(MODE_UDEC, 64'd0);
		send_item(MODE_UDEC, 64'hffff_ffff_ffff_ffff);
		send_item(MODE_UDEC, 64'h0000_0000_8000_0000);
		send_item(MODE_UDEC, 64'd1000000000);
		send_item(MODE_HEXL, 64'd0);
		send_item(MODE_HEXL, 64'hffff_ffff_ffff_ffff);
		send_item(MODE_HEXL, 64'h0123_4567_89ab_cdef);
		send_item(MODE_HEXU, 64'hfedc_ba98_7654_3210);
		send_item(MODE_HEXU, 64'd0);
		send_item(MODE_HEXU, 64'h0000_0000_0000_000a);
		send_item(MODE_PTR, 64'd0);
		send_item(MODE_PTR, 64'hffff_ffff_ffff_ffff);
		send_item(MODE_PTR, 64'h1);
		for (m = FIRST_UNUSED; m <= LAST_UNUSED; m++)
			send_item(m[2:0], 64'hffff_ffff_ffff_ffff);
		send_item(MODE_PTR, 64'h8000_0000_0000_0000);

		// hold off the sender until all text is out
		wait_drained();

		while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			if (items_sent % 40 == 10)
				quiet = 1'b1;
			else if (items_sent % 40 == 25)
				quiet = 1'b0;
			if (items_sent == 100)
				wait_drained();
			if ($urandom_range(0, 19) < 2)
				send_item(3'($urandom_range(FIRST_UNUSED, LAST_UNUSED)), random_value());
			else
				send_item(3'($urandom_range(int'(MODE_SDEC), int'(MODE_PTR))),
					random_value());
		end
		quiet = 1'b0;

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d items over all five modes and %0d with unused mode codes;",
			items_sent, unused_sent);
		$display("%0d characters checked, %0d mismatches", chars_seen, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
